FILE: hdl/kcf_pkg.sv
package kcf_pkg;

    localparam int CMD_W  = 2;
    localparam int SYM_W  = 3;
    localparam int IDX_W  = 12;
    localparam int FREQ_W = 17;
    localparam int LEN_W  = 3;
    localparam int CFG_IDX_W = 1;

    localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_KMER_LENGTH   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PREFIX_LENGTH = 1'b1;

    localparam logic [LEN_W-1:0] KMER_LENGTH_RESET   = 3'd2;
    localparam logic [LEN_W-1:0] PREFIX_LENGTH_RESET = 3'd1;

    localparam logic [FREQ_W-1:0] ONE_Q16 = 17'h10000;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [SYM_W-1:0] symbol;
        logic [IDX_W-1:0] read_index;
    } cmd_t;

    typedef struct packed {
        logic [FREQ_W-1:0] frequency;
        logic              config_error;
    } res_t;

endpackage

FILE: hdl/kmer_conditional_frequency.sv
// Push: the count tables are read, then written back; nothing is written when no window is counted.
// Read: the result beat comes from the 17-step serial divider; an unseen prefix or a ratio of
// two or more skips the division steps, and a bad configuration or index answers from idle.
// Clear: all 4^MAX_K entries (4096 by default) are zeroed, one table entry per cycle.
// After reset a clearing pass over all 4^MAX_K entries runs before busy falls; the result
// strobe lasts one cycle and cannot be stalled.
module kmer_conditional_frequency #(
    parameter int MAX_K      = 6,
    parameter int COUNT_BITS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  kcf_pkg::cmd_t                 cmd,
    output logic                          result_valid,
    output kcf_pkg::res_t                 result,
    input  logic                          cfg_we,
    input  logic [kcf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [kcf_pkg::LEN_W-1:0]     cfg_data
);
    import kcf_pkg::*;

    localparam int KAW   = 2 * MAX_K;
    localparam int PAW   = 2 * (MAX_K - 1);
    localparam int DPW   = PAW + 1;
    localparam int RUN_W = $clog2(MAX_K + 1);
    localparam int SRC_W = KAW + IDX_W;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_PUSH  = 4'b0010,
        S_READ  = 4'b0100,
        S_CLEAR = 4'b1000
    } state_t;

    state_t               state_reg, state_next;
    logic [LEN_W-1:0]     klen_reg, plen_reg;
    logic [KAW-1:0]       win_reg, win_next;
    logic [RUN_W-1:0]     run_reg, run_next;
    logic [DPW-1:0]       distinct_reg, distinct_next;
    logic [KAW-1:0]       clr_reg, clr_next;
    logic [KAW-1:0]       kidx_reg, kidx_next;
    logic [PAW-1:0]       pidx_reg, pidx_next;
    logic                 go_reg, go_next;
    logic                 rv_reg, rv_next;
    res_t                 res_reg, res_next;

    logic                 accept, cfg_bad, sym_ok, out_range;
    logic [KAW-1:0]       kmask, kfull;
    logic [SRC_W-1:0]     src;
    logic [KAW-1:0]       kidx;
    logic [PAW-1:0]       pidx;
    logic [COUNT_BITS-1:0] k_rdata, p_rdata;
    logic                 k_we, p_we;
    logic [KAW-1:0]       k_waddr;
    logic [PAW-1:0]       p_waddr;
    logic [COUNT_BITS-1:0] k_wdata, p_wdata;
    logic                 div_done;
    logic [FREQ_W-1:0]    div_quot;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    assign cfg_bad = ({1'b0, klen_reg} > (LEN_W+1)'(MAX_K)) || (plen_reg >= klen_reg);
    assign sym_ok  = (cmd.symbol <= SYM_W'(3));

    assign win_next = {win_reg[KAW-3:0], cmd.symbol[1:0]};
    assign run_next = !sym_ok ? '0 : ((run_reg == RUN_W'(MAX_K)) ? run_reg : run_reg + 1'b1);

    // Shifting by at least the width leaves the mask all ones.
    assign kmask     = ~({KAW{1'b1}} << (2 * klen_reg));
    assign kfull     = win_next & kmask;
    assign out_range = ((cmd.read_index >> (2 * klen_reg)) != '0);

    assign src  = (cmd.command == CMD_PUSH) ? SRC_W'(kfull) : SRC_W'(cmd.read_index);
    assign kidx = src[KAW-1:0];
    assign pidx = PAW'(src >> (2 * (klen_reg - plen_reg)));

    always_comb
    begin
        state_next    = state_reg;
        distinct_next = distinct_reg;
        clr_next      = clr_reg;
        kidx_next     = kidx_reg;
        pidx_next     = pidx_reg;
        go_next       = 1'b0;
        rv_next       = 1'b0;
        res_next      = res_reg;
        k_we          = 1'b0;
        p_we          = 1'b0;
        k_waddr       = kidx_reg;
        p_waddr       = pidx_reg;
        k_wdata       = (&k_rdata) ? k_rdata : k_rdata + 1'b1;
        p_wdata       = (&p_rdata) ? p_rdata : p_rdata + 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    kidx_next = kidx;
                    pidx_next = pidx;
                    case (cmd.command)
                        CMD_PUSH:
                        begin
                            if (!cfg_bad && sym_ok && ({1'b0, run_next} >= (RUN_W+1)'(klen_reg)))
                            begin
                                state_next = S_PUSH;
                            end
                        end
                        CMD_READ:
                        begin
                            if (cfg_bad)
                            begin
                                rv_next  = 1'b1;
                                res_next = '{frequency: '0, config_error: 1'b1};
                            end
                            else if (out_range)
                            begin
                                rv_next  = 1'b1;
                                res_next = '{frequency: '0, config_error: 1'b0};
                            end
                            else
                            begin
                                go_next    = 1'b1;
                                state_next = S_READ;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            distinct_next = '0;
                            clr_next      = '0;
                            state_next    = S_CLEAR;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_PUSH:
            begin
                k_we = 1'b1;
                p_we = 1'b1;
                if ((p_rdata == '0) && (distinct_reg != DPW'(1 << PAW)))
                begin
                    distinct_next = distinct_reg + 1'b1;
                end
                state_next = S_IDLE;
            end
            S_READ:
            begin
                if (div_done)
                begin
                    rv_next    = 1'b1;
                    res_next   = '{frequency: div_quot, config_error: 1'b0};
                    state_next = S_IDLE;
                end
            end
            S_CLEAR:
            begin
                k_we    = 1'b1;
                p_we    = 1'b1;
                k_waddr = clr_reg;
                p_waddr = clr_reg[PAW-1:0];
                k_wdata = '0;
                p_wdata = '0;
                clr_next = clr_reg + 1'b1;
                if (&clr_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            klen_reg     <= KMER_LENGTH_RESET;
            plen_reg     <= PREFIX_LENGTH_RESET;
            win_reg      <= '0;
            run_reg      <= '0;
            distinct_reg <= '0;
            clr_reg      <= '0;
            go_reg       <= 1'b0;
            rv_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            distinct_reg <= distinct_next;
            clr_reg      <= clr_next;
            go_reg       <= go_next;
            rv_reg       <= rv_next;
            if (accept && (cmd.command == CMD_PUSH))
            begin
                win_reg <= win_next;
                run_reg <= run_next;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_KMER_LENGTH:   klen_reg <= cfg_data;
                    REG_PREFIX_LENGTH: plen_reg <= cfg_data;
                    default:           klen_reg <= klen_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kidx_reg <= kidx_next;
        pidx_reg <= pidx_next;
        res_reg  <= res_next;
    end

    kcf_ram #(.AW(KAW), .DW(COUNT_BITS)) u_kmer_ram (
        .clk   (clk),
        .we    (k_we),
        .waddr (k_waddr),
        .wdata (k_wdata),
        .raddr (kidx),
        .rdata (k_rdata)
    );

    kcf_ram #(.AW(PAW), .DW(COUNT_BITS)) u_prefix_ram (
        .clk   (clk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (p_wdata),
        .raddr (pidx),
        .rdata (p_rdata)
    );

    kcf_divider #(.CB(COUNT_BITS), .DPW(DPW)) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (go_reg),
        .num      (k_rdata),
        .pcnt     (p_rdata),
        .distinct (distinct_reg),
        .done     (div_done),
        .quot     (div_quot)
    );

    assign result_valid = rv_reg;
    assign result       = res_reg;

endmodule

FILE: hdl/kcf_ram.sv
module kcf_ram #(
    parameter int AW = 12,
    parameter int DW = 32
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [(1 << AW)];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/kcf_divider.sv
module kcf_divider #(
    parameter int CB  = 32,
    parameter int DPW = 11
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      go,
    input  logic [CB-1:0]             num,
    input  logic [CB-1:0]             pcnt,
    input  logic [DPW-1:0]            distinct,
    output logic                      done,
    output logic [kcf_pkg::FREQ_W-1:0] quot
);
    import kcf_pkg::*;

    localparam int DEN_W = CB + DPW;
    localparam int STEPS = FREQ_W;
    localparam int STW   = $clog2(STEPS);

    typedef enum logic [3:0] {
        D_IDLE = 4'b0001,
        D_CHK  = 4'b0010,
        D_DIV  = 4'b0100,
        D_DONE = 4'b1000
    } dstate_t;

    dstate_t           state_reg, state_next;
    logic [DEN_W-1:0]  den_reg, den_next;
    logic [DEN_W:0]    rem_reg, rem_next;
    logic [FREQ_W-1:0] quot_reg, quot_next;
    logic [STW-1:0]    step_reg, step_next;
    logic [DEN_W:0]    cand;
    logic              fits;

    // The first quotient bit weighs one; the numerator is already below twice the divisor.
    assign cand = (step_reg == '0) ? rem_reg : {rem_reg[DEN_W-1:0], 1'b0};
    assign fits = cand >= {1'b0, den_reg};

    always_comb
    begin
        state_next = state_reg;
        den_next   = den_reg;
        rem_next   = rem_reg;
        quot_next  = quot_reg;
        step_next  = step_reg;
        case (state_reg)
            D_IDLE:
            begin
                if (go)
                begin
                    den_next   = pcnt * distinct;
                    rem_next   = (DEN_W+1)'(num);
                    step_next  = '0;
                    quot_next  = '0;
                    state_next = D_CHK;
                end
            end
            D_CHK:
            begin
                if (den_reg == '0)
                begin
                    quot_next  = '0;
                    state_next = D_DONE;
                end
                else if (rem_reg >= {den_reg, 1'b0})
                begin
                    quot_next  = ONE_Q16;
                    state_next = D_DONE;
                end
                else
                begin
                    state_next = D_DIV;
                end
            end
            D_DIV:
            begin
                rem_next  = fits ? (cand - {1'b0, den_reg}) : cand;
                quot_next = {quot_reg[FREQ_W-2:0], fits};
                step_next = step_reg + 1'b1;
                if (step_reg == STW'(STEPS - 1))
                begin
                    state_next = D_DONE;
                end
            end
            D_DONE:
            begin
                if (quot_reg > ONE_Q16)
                begin
                    quot_next = ONE_Q16;
                end
                state_next = D_IDLE;
            end
            default:
            begin
                state_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
    end

    assign done = (state_reg == D_DONE);
    assign quot = (quot_reg > ONE_Q16) ? ONE_Q16 : quot_reg;

endmodule

FILE: verif/kmer_conditional_frequency_tb.sv
`timescale 1ns / 1ps

module kmer_conditional_frequency_tb;
    import kcf_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int KMAX = 6;
    localparam int KMER_N = 1 << (2 * KMAX);
    localparam int PREFIX_N = 1 << (2 * (KMAX - 1));
    localparam longint COUNT_TOP = 64'hFFFF_FFFF;
    localparam int CYCLE_LIMIT = 900000;
    localparam int SETTLE = 40;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    cmd_t cmd = '0;
    logic result_valid;
    res_t result;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [LEN_W-1:0] cfg_data = '0;

    kmer_conditional_frequency dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .result_valid(result_valid), .result(result),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Shadow copy of the counting state.
    logic [LEN_W-1:0] k_len = KMER_LENGTH_RESET;
    logic [LEN_W-1:0] p_len = PREFIX_LENGTH_RESET;
    logic [11:0] window_bits = '0;
    logic [2:0] run_len = '0;
    longint kmer_tally [KMER_N];
    longint prefix_tally [PREFIX_N];
    int distinct_seen = 0;

    cmd_t pending [$];
    res_t freq_expected [$];
    int mismatches = 0;
    int cycles = 0;
    bit hold_off = 1'b0;
    bit no_idle = 1'b0;
    logic [11:0] gen_window = '0;

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic bit setting_bad();
        return (k_len > KMAX) || (p_len >= k_len);
    endfunction

    function automatic void wipe_tallies();
        foreach (kmer_tally[i]) kmer_tally[i] = 0;
        foreach (prefix_tally[i]) prefix_tally[i] = 0;
        distinct_seen = 0;
    endfunction

    function automatic void count_symbol(logic [SYM_W-1:0] sym);
        int kidx;
        int pidx;
        window_bits = {window_bits[9:0], sym[1:0]};
        if (sym > 3) begin
            run_len = 0;
            return;
        end
        if (run_len < KMAX) run_len++;
        if (setting_bad() || run_len < k_len) return;
        kidx = int'(window_bits) & ((1 << (2 * k_len)) - 1);
        pidx = (kidx >> (2 * (k_len - p_len))) & (PREFIX_N - 1);
        if (kmer_tally[kidx] < COUNT_TOP) kmer_tally[kidx]++;
        if (prefix_tally[pidx] == 0 && distinct_seen < PREFIX_N) distinct_seen++;
        if (prefix_tally[pidx] < COUNT_TOP) prefix_tally[pidx]++;
    endfunction

    function automatic res_t lookup_frequency(logic [IDX_W-1:0] idx);
        res_t r;
        int pidx;
        longint unsigned num;
        longint unsigned den;
        longint unsigned q;
        r = '0;
        if (setting_bad()) begin
            r.config_error = 1'b1;
            return r;
        end
        if (int'(idx) >= (1 << (2 * k_len))) return r;
        pidx = (int'(idx) >> (2 * (k_len - p_len))) & (PREFIX_N - 1);
        num = kmer_tally[idx];
        den = longint'(prefix_tally[pidx]) * longint'(distinct_seen);
        if (den == 0) return r;
        q = (num << 16) / den;
        r.frequency = (q > 65536) ? ONE_Q16 : q[FREQ_W-1:0];
        return r;
    endfunction

    // Driver: a beat is taken at an edge with start high and busy low.
    always @(posedge clk) begin
        if (rst_n) begin
            if (start && !busy) begin
                case (cmd.command)
                    CMD_PUSH: count_symbol(cmd.symbol);
                    CMD_READ: freq_expected.insert(freq_expected.size(),
                                                   lookup_frequency(cmd.read_index));
                    CMD_CLEAR: wipe_tallies();
                    default: ;
                endcase
            end
            if (!start || !busy) begin
                if (pending.size() > 0 && !hold_off
                        && (no_idle || $urandom_range(99) >= 27)) begin
                    start <= 1'b1;
                    cmd <= pending.pop_front();
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
        if (rst_n && result_valid) begin
            if (freq_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: freq=%0d err=%0b",
                             result.frequency, result.config_error);
            end else begin
                res_t e;
                e = freq_expected.pop_front();
                if (e.frequency !== result.frequency
                        || e.config_error !== result.config_error) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected freq=%0d err=%0b, got freq=%0d err=%0b",
                                 e.frequency, e.config_error,
                                 result.frequency, result.config_error);
                end
            end
        end
    end

    function automatic cmd_t make_cmd(logic [CMD_W-1:0] c, logic [SYM_W-1:0] s,
                                      logic [IDX_W-1:0] i);
        cmd_t x;
        x.command = c;
        x.symbol = s;
        x.read_index = i;
        return x;
    endfunction

    task automatic enqueue(cmd_t c);
        pending.insert(pending.size(), c);
    endtask

    task automatic queue_push(logic [SYM_W-1:0] s);
        enqueue(make_cmd(CMD_PUSH, s, IDX_W'($urandom)));
        if (s <= 3) gen_window = {gen_window[9:0], s[1:0]};
    endtask

    task automatic queue_read(logic [IDX_W-1:0] i);
        enqueue(make_cmd(CMD_READ, SYM_W'($urandom), i));
    endtask

    task automatic drain();
        wait (pending.size() == 0);
        @(posedge clk);
        while (start || busy || freq_expected.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] r, logic [LEN_W-1:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= r;
        cfg_data <= v;
        if (r == REG_KMER_LENGTH) k_len = v;
        else p_len = v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_phase(int n, int klen_hint);
        int roll;
        int sym;
        for (int j = 0; j < n; j++) begin
            roll = $urandom_range(999);
            if (roll < 620) begin
                sym = ($urandom_range(99) < 6) ? $urandom_range(7, 4) : $urandom_range(3);
                queue_push(SYM_W'(sym));
            end else if (roll < 860) begin
                queue_read(gen_window & IDX_W'((1 << (2 * klen_hint)) - 1));
            end else if (roll < 990) begin
                queue_read(IDX_W'($urandom));
            end else if (roll < 996) begin
                enqueue(make_cmd(CMD_UNUSED, SYM_W'($urandom), IDX_W'($urandom)));
            end else begin
                enqueue(make_cmd(CMD_CLEAR, SYM_W'($urandom), IDX_W'($urandom)));
            end
        end
    endtask

    initial begin
        int klist [10] = '{2, 6, 6, 3, 4, 5, 2, 7, 0, 6};
        int plist [10] = '{1, 5, 0, 1, 2, 4, 2, 3, 0, 6};
        wipe_tallies();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed beats under the reset lengths.
        for (int s = 0; s < 4; s++) queue_push(SYM_W'(s));
        queue_push(3'd4);
        queue_push(3'd7);
        queue_push(3'd0);
        queue_push(3'd0);
        queue_read(12'd0);
        queue_read(12'd15);
        queue_read(12'd4095);
        queue_read(12'd5);
        enqueue(make_cmd(CMD_UNUSED, 3'd7, 12'hFFF));
        enqueue(make_cmd(CMD_CLEAR, 3'd0, 12'd0));
        queue_read(12'd0);
        queue_push(3'd3);
        queue_push(3'd3);
        queue_push(3'd3);
        queue_read(12'd15);
        drain();

        // Lengthening the window without a clear can push the ratio past one.
        write_reg(REG_KMER_LENGTH, 3'd3);
        write_reg(REG_PREFIX_LENGTH, 3'd2);
        queue_push(3'd3);
        queue_read(12'd63);
        queue_read(12'd0);
        drain();

        for (int ph = 0; ph < 10; ph++) begin
            write_reg(REG_KMER_LENGTH, LEN_W'(klist[ph]));
            write_reg(REG_PREFIX_LENGTH, LEN_W'(plist[ph]));
            if (ph % 2 == 0)
                enqueue(make_cmd(CMD_CLEAR, SYM_W'($urandom), IDX_W'($urandom)));
            no_idle = (ph == 3);
            random_phase(170, (klist[ph] > KMAX || klist[ph] < 1) ? 2 : klist[ph]);
            if (ph == 4) begin
                wait (pending.size() < 80);
                hold_off = 1'b1;
                @(posedge clk);
                while (start || busy || freq_expected.size() != 0) @(posedge clk);
                hold_off = 1'b0;
            end
            drain();
        end

        if (mismatches == 0 && freq_expected.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
